/* rtl/act_pkg.sv */
package act_pkg;

  localparam int unsigned BlockBits = 128;
  localparam int unsigned Rounds = 10;
  localparam logic [7:0] GfReduce = 8'h87;
  localparam logic [7:0] PadByte = 8'h80;
  localparam logic [4:0] FullCount = 5'd16;

  typedef logic [BlockBits-1:0] blk_t;

  localparam logic [0:0] RegKeyHigh = 1'b0;
  localparam logic [0:0] RegKeyLow = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_key;     // round key 0 <- cipher key, round counter reset
    logic start_zero;   // begin encryption of the zero block
    logic start_msg;    // begin encryption of the prepared message block
    logic do_round;     // run one cipher round and advance the key schedule
    logic save_sub;     // store the derived subkeys
    logic save_chain;   // chain <- cipher state
    logic clear_chain;  // chain <- zero
  } act_cmd_t;

  typedef struct packed {
    logic last_round;   // the round now running is round ten
  } act_sts_t;

  localparam logic [7:0] Sbox [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  function automatic logic [7:0] xtime(input logic [7:0] b);
    xtime = {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    sub_word = {Sbox[w[31:24]], Sbox[w[23:16]], Sbox[w[15:8]], Sbox[w[7:0]]};
  endfunction

  // One AES round without the key addition (the final round skips MixColumns); byte 0 is the top byte.
  function automatic blk_t aes_round(input blk_t s, input logic final_rnd);
    logic [7:0] sb [16];
    logic [7:0] t [16];
    logic [7:0] o [16];
    logic [7:0] al;
    blk_t r;
    for (int i = 0; i < 16; i++) begin
      sb[i] = Sbox[s[127-8*i -: 8]];
    end
    for (int c = 0; c < 4; c++) begin
      for (int i = 0; i < 4; i++) begin
        t[i+4*c] = sb[i + 4*((c+i)%4)];
      end
    end
    for (int c = 0; c < 4; c++) begin
      al = t[4*c] ^ t[4*c+1] ^ t[4*c+2] ^ t[4*c+3];
      o[4*c]   = t[4*c]   ^ al ^ xtime(t[4*c]   ^ t[4*c+1]);
      o[4*c+1] = t[4*c+1] ^ al ^ xtime(t[4*c+1] ^ t[4*c+2]);
      o[4*c+2] = t[4*c+2] ^ al ^ xtime(t[4*c+2] ^ t[4*c+3]);
      o[4*c+3] = t[4*c+3] ^ al ^ xtime(t[4*c+3] ^ t[4*c]);
    end
    for (int i = 0; i < 16; i++) begin
      r[127-8*i -: 8] = final_rnd ? t[i] : o[i];
    end
    aes_round = r;
  endfunction

  function automatic blk_t next_rkey(input blk_t k, input logic [7:0] rc);
    logic [31:0] w0, w1, w2, w3;
    w0 = k[127:96] ^ sub_word({k[23:0], k[31:24]}) ^ {rc, 24'h0};
    w1 = k[95:64] ^ w0;
    w2 = k[63:32] ^ w1;
    w3 = k[31:0] ^ w2;
    next_rkey = {w0, w1, w2, w3};
  endfunction

  function automatic blk_t gf_double(input blk_t v);
    gf_double = {v[126:0], 1'b0} ^ (v[127] ? {120'h0, GfReduce} : '0);
  endfunction

endpackage

/* rtl/act_datapath.sv */
module act_datapath (
  input  logic               clk,
  input  act_pkg::act_cmd_t  cmd,
  output act_pkg::act_sts_t  sts,
  input  logic               rst_n,
  input  act_pkg::blk_t      key,
  input  act_pkg::blk_t      blk,
  input  logic [4:0]         byte_count,
  input  logic               last,
  output act_pkg::blk_t      state
);
  import act_pkg::*;

  blk_t state_r, state_nxt;
  blk_t rkey_r, rkey_nxt;
  blk_t key0_r;
  blk_t k1_r, k2_r;
  blk_t chain_r;
  logic [3:0] rnd_r;
  logic [7:0] rcon_r;
  blk_t msg, mask, pad;
  logic [4:0] n;

  // Padding: keep n bytes, put the pad byte right after them.
  always_comb begin
    n = (byte_count > FullCount) ? FullCount : byte_count;
    for (int i = 0; i < 16; i++) begin
      mask[127-8*i -: 8] = (5'(i) < n) ? 8'hff : 8'h00;
      pad[127-8*i -: 8]  = (5'(i) == n) ? PadByte : 8'h00;
    end
    if (!last) msg = blk;
    else if (n == FullCount) msg = blk ^ k1_r;
    else msg = ((blk & mask) | pad) ^ k2_r;
  end

  always_comb begin
    state_nxt = state_r;
    rkey_nxt = rkey_r;
    if (cmd.start_zero) state_nxt = key0_r;
    else if (cmd.start_msg) state_nxt = chain_r ^ msg ^ key0_r;
    else if (cmd.do_round) begin
      rkey_nxt = next_rkey(rkey_r, rcon_r);
      state_nxt = aes_round(state_r, rnd_r == 4'(Rounds)) ^ rkey_nxt;
    end
    if (cmd.load_key || cmd.start_zero || cmd.start_msg) rkey_nxt = key0_r;
  end

  always_ff @(posedge clk) begin
    if (cmd.load_key) key0_r <= key;
    state_r <= state_nxt;
    rkey_r <= cmd.load_key ? key : rkey_nxt;
    if (cmd.save_sub) begin
      k1_r <= gf_double(state_r);
      k2_r <= gf_double(gf_double(state_r));
    end
    if (cmd.start_zero || cmd.start_msg || cmd.load_key) begin
      rnd_r <= 4'd1;
      rcon_r <= 8'h01;
    end else if (cmd.do_round) begin
      rnd_r <= rnd_r + 4'd1;
      rcon_r <= xtime(rcon_r);
    end
  end

  // The chain takes the result of the round that is finishing this cycle.
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clear_chain) chain_r <= '0;
    else if (cmd.save_chain) chain_r <= state_nxt;
  end

  assign sts.last_round = (rnd_r == 4'(Rounds));
  // The state as it will be after this edge, so a finished round is seen at once.
  assign state = state_nxt;
endmodule

/* rtl/act_ctrl.sv */
module act_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               key_written,
  input  logic               in_go,
  input  logic               last,
  input  logic               out_free,
  input  act_pkg::act_sts_t  sts,
  output act_pkg::act_cmd_t  cmd,
  output logic               in_ready,
  output logic               out_load
);
  import act_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_KEY   = 6'b000010,
    S_KRND  = 6'b000100,
    S_MSG   = 6'b001000,
    S_RND   = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  state_t st_r, st_nxt;
  logic ready_keys_r, ready_keys_nxt;
  logic last_r, last_nxt;

  always_comb begin
    st_nxt = st_r;
    ready_keys_nxt = ready_keys_r;
    last_nxt = last_r;
    cmd = '0;
    in_ready = 1'b0;
    out_load = 1'b0;
    unique case (st_r)
      S_IDLE: begin
        in_ready = out_free;
        if (in_go) begin
          last_nxt = last;
          if (ready_keys_r) begin
            cmd.start_msg = 1'b1;
            st_nxt = S_RND;
          end else begin
            cmd.load_key = 1'b1;
            st_nxt = S_KEY;
          end
        end
      end
      S_KEY: begin
        cmd.start_zero = 1'b1;
        st_nxt = S_KRND;
      end
      S_KRND: begin
        cmd.do_round = 1'b1;
        if (sts.last_round) st_nxt = S_MSG;
      end
      S_MSG: begin
        cmd.save_sub = 1'b1;
        ready_keys_nxt = 1'b1;
        st_nxt = S_DONE;
      end
      S_DONE: begin
        cmd.start_msg = 1'b1;
        st_nxt = S_RND;
      end
      S_RND: begin
        cmd.do_round = 1'b1;
        if (sts.last_round) st_nxt = S_IDLE;
      end
      default: st_nxt = S_IDLE;
    endcase
    // Finishing a message block: a final block hands its tag to the output
    // and restarts the chain, any other block becomes the new chain value.
    if (st_r == S_RND && sts.last_round) begin
      out_load = last_r;
      cmd.clear_chain = last_r;
      cmd.save_chain = !last_r;
    end
    if (key_written) ready_keys_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      ready_keys_r <= 1'b0;
      last_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      ready_keys_r <= ready_keys_nxt;
      last_r <= last_nxt;
    end
  end
endmodule

/* rtl/aes128_cmac_tag_top.sv */
// AES-128 CMAC tag engine.
// The key is to be written through the cfg_ channel (index 0 = upper key
// half, index 1 = lower half) only while the block is idle; the block itself
// does not enforce this. A message enters on the in_ channel as one 16-byte
// block per beat; in_last marks the final block, whose in_byte_count (0..16,
// larger values count as 16) selects K1 or 0x80-padding with K2. The final
// block yields one beat on the out_ channel with the tag and a mismatch flag
// (set only when in_check was set and the tag differs). A new block is taken
// only after the current one is done: the accepting cycle loads the first
// key addition, then the ten rounds run iteratively on the single AES round
// unit. The first block after reset or a key write first encrypts the zero
// block for key expansion and subkey derivation. The tag is registered on
// out_ at the edge that ends the tenth round. A stalled receiver holds the
// result in the output register; a new block is taken only when the output
// register is free, so nothing is lost. Reset clears the control state, the
// chain value and the key-valid flag; key registers reset to zero.
module aes128_cmac_tag_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [0:0]  cfg_index,
  input  logic [63:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [63:0] in_block_high,
  input  logic [63:0] in_block_low,
  input  logic [4:0]  in_byte_count,
  input  logic        in_last,
  input  logic        in_check,
  input  logic [63:0] in_expected_high,
  input  logic [63:0] in_expected_low,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] out_tag_high,
  output logic [63:0] out_tag_low,
  output logic        out_mismatch
);
  import act_pkg::*;

  logic [63:0] key_high_r, key_low_r;
  blk_t blk_r, exp_r;
  logic [4:0] cnt_r;
  logic last_r, check_r;
  logic out_valid_r;
  blk_t tag_r;
  logic mis_r;
  logic in_go, cfg_go, out_load, out_free;
  act_cmd_t cmd;
  act_sts_t sts;
  blk_t state;

  assign cfg_ready = 1'b1;
  assign cfg_go = cfg_valid && cfg_ready;
  assign in_go = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_high_r <= '0;
      key_low_r <= '0;
    end else if (cfg_go) begin
      unique case (cfg_index)
        RegKeyHigh: key_high_r <= cfg_data;
        RegKeyLow:  key_low_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input beat is held for the whole computation.
  always_ff @(posedge clk) begin
    if (in_go) begin
      blk_r <= {in_block_high, in_block_low};
      exp_r <= {in_expected_high, in_expected_low};
      cnt_r <= in_byte_count;
      last_r <= in_last;
      check_r <= in_check;
    end
  end

  act_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .key_written(cfg_go), .in_go(in_go), .last(in_last),
    .out_free(out_free), .sts(sts), .cmd(cmd), .in_ready(in_ready), .out_load(out_load)
  );

  blk_t dp_blk;
  assign dp_blk = in_go ? {in_block_high, in_block_low} : blk_r;
  logic [4:0] dp_cnt;
  assign dp_cnt = in_go ? in_byte_count : cnt_r;
  logic dp_last;
  assign dp_last = in_go ? in_last : last_r;

  act_datapath u_dp (
    .clk(clk), .cmd(cmd), .sts(sts), .rst_n(rst_n),
    .key({key_high_r, key_low_r}), .blk(dp_blk), .byte_count(dp_cnt),
    .last(dp_last), .state(state)
  );

  // Round ten's result is on state during the out_load cycle; capture it then.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      tag_r <= state;
      mis_r <= check_r && (state != exp_r);
    end
  end

  assign out_valid = out_valid_r;
  assign out_tag_high = tag_r[127:64];
  assign out_tag_low = tag_r[63:0];
  assign out_mismatch = mis_r;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped under stall");
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_tag_high) && $stable(out_tag_low)
      && $stable(out_mismatch))
    else $error("result changed under stall");
  a_no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken while a tag is stalled");
endmodule
